@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros are inactive while the synchronous reset is asserted.

// The consequent must hold in the same cycle as the antecedent.
`define GSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/gsc_pkg.sv @@
package gsc_pkg;

  localparam int LAT_W    = 27;
  localparam int LON_W    = 28;
  localparam int LVL_W    = 3;
  localparam int FACTOR_W = 10;

  localparam int MICRO         = 1000000;
  localparam int LAT_DIV       = 2 * MICRO;
  localparam int LON_DIV       = MICRO;
  localparam int DEC_DIV       = 10;
  localparam int LON_ORIGIN    = 100000000;
  localparam int PRIMARY_LIMIT = 100;

  // Three times the latitude needs two more bits than the latitude.
  localparam int Y_W = LAT_W + 2;
  localparam int D_W = LON_W;

  localparam int LAT1_Q_W = $clog2(((longint'(1) << Y_W) / LAT_DIV) + 1);
  localparam int LAT1_R_W = $clog2(LAT_DIV);
  localparam int LON1_Q_W = $clog2(((longint'(1) << D_W) / LON_DIV) + 1);
  localparam int LON1_R_W = $clog2(LON_DIV);

  localparam int TLAT_W   = FACTOR_W + LAT1_R_W;
  localparam int TLON_W   = FACTOR_W + LON1_R_W;
  localparam int LAT2_Q_W = $clog2(((longint'(1) << TLAT_W) / LAT_DIV) + 1);
  localparam int LON2_Q_W = $clog2(((longint'(1) << TLON_W) / LON_DIV) + 1);

  localparam int IDX_W    = FACTOR_W + LAT1_Q_W;
  localparam int DEC_Q_W  = $clog2(((longint'(1) << IDX_W) / DEC_DIV) + 1);
  localparam int DEC_R_W  = $clog2(DEC_DIV);

  localparam logic [LVL_W-1:0] LVL_FIRST   = 3'd1;
  localparam logic [LVL_W-1:0] LVL_SECOND  = 3'd2;
  localparam logic [LVL_W-1:0] LVL_THIRD   = 3'd3;
  localparam logic [LVL_W-1:0] LVL_HALF    = 3'd4;
  localparam logic [LVL_W-1:0] LVL_QUARTER = 3'd5;
  localparam logic [LVL_W-1:0] LVL_EIGHTH  = 3'd6;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_LEVEL = 2'd1,
    ST_LAT_RANGE = 2'd2,
    ST_LON_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic [LAT_W-1:0] lat_micro;
    logic [LON_W-1:0] lon_micro;
    logic [LVL_W-1:0] level;
  } gsc_in_t;

  typedef struct packed {
    status_t    status;
    logic [6:0] lat_primary;
    logic [6:0] lon_primary;
    logic [2:0] lat_second;
    logic [2:0] lon_second;
    logic [3:0] lat_third;
    logic [3:0] lon_third;
    logic [2:0] half_code;
    logic [2:0] quarter_code;
    logic [2:0] eighth_code;
  } gsc_out_t;

  // Scaled indices handed to the digit splitter.
  typedef struct packed {
    logic [LVL_W-1:0] lvl;
    status_t          status;
    logic [IDX_W-1:0] lat_idx;
    logic [IDX_W-1:0] lon_idx;
  } gsc_idx_t;

  function automatic logic [FACTOR_W-1:0] level_factor(input logic [LVL_W-1:0] lvl);
    logic [FACTOR_W-1:0] f;
    case (lvl)
      LVL_FIRST:   f = FACTOR_W'(1);
      LVL_SECOND:  f = FACTOR_W'(8);
      LVL_THIRD:   f = FACTOR_W'(80);
      LVL_HALF:    f = FACTOR_W'(160);
      LVL_QUARTER: f = FACTOR_W'(320);
      LVL_EIGHTH:  f = FACTOR_W'(640);
      default:     f = '0;
    endcase
    return f;
  endfunction

endpackage

@@ rtl/core/grid_square_code_encoder.sv @@
// Throughput: one position per cycle; busy is always low and the pipeline never stalls.
// The depth is set by two reciprocal dividers (by the degree unit, then again after scaling)
// and the divide by ten, each three stages, plus five single stages around them.
// Reset clears only the valid bits of the pipeline; positions in flight at reset give no result.
`include "assert_macros.svh"

module grid_square_code_encoder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  gsc_pkg::gsc_in_t  in_data,
  output logic              busy,
  output logic              out_strobe,
  output gsc_pkg::gsc_out_t out_data
);

  typedef struct packed {
    logic [gsc_pkg::LVL_W-1:0] lvl;
    logic [gsc_pkg::IDX_W-1:0] base;
  } lat_side_t;

  typedef struct packed {
    gsc_pkg::status_t          status;
    logic [gsc_pkg::IDX_W-1:0] base;
  } lon_side_t;

  logic                         accept;
  gsc_pkg::status_t             fr_status_nxt;
  logic                         fr_vld_r;
  logic [gsc_pkg::Y_W-1:0]      fr_y_r;
  logic [gsc_pkg::D_W-1:0]      fr_d_r;
  logic [gsc_pkg::LVL_W-1:0]    fr_lvl_r;
  gsc_pkg::status_t             fr_status_r;

  logic                         c1_lat_valid;
  logic                         c1_lon_valid;
  logic [gsc_pkg::LAT1_Q_W-1:0] c1_lat_quo;
  logic [gsc_pkg::LON1_Q_W-1:0] c1_lon_quo;
  logic [gsc_pkg::LAT1_R_W-1:0] c1_lat_rem;
  logic [gsc_pkg::LON1_R_W-1:0] c1_lon_rem;
  logic [gsc_pkg::LVL_W-1:0]    c1_lvl;
  logic [1:0]                   c1_status;

  logic [gsc_pkg::FACTOR_W-1:0] factor;
  logic                         sc_vld_r;
  logic [gsc_pkg::TLAT_W-1:0]   sc_t_lat_r;
  logic [gsc_pkg::TLON_W-1:0]   sc_t_lon_r;
  lat_side_t                    sc_lat_r;
  lon_side_t                    sc_lon_r;

  logic                         c2_lat_valid;
  logic                         c2_lon_valid;
  logic [gsc_pkg::LAT2_Q_W-1:0] c2_lat_quo;
  logic [gsc_pkg::LON2_Q_W-1:0] c2_lon_quo;
  lat_side_t                    c2_lat_side;
  lon_side_t                    c2_lon_side;

  logic                         ix_vld_r;
  gsc_pkg::gsc_idx_t            ix_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    if (in_data.level < gsc_pkg::LVL_FIRST || in_data.level > gsc_pkg::LVL_EIGHTH) begin
      fr_status_nxt = gsc_pkg::ST_BAD_LEVEL;
    end else if (in_data.lon_micro < gsc_pkg::LON_W'(gsc_pkg::LON_ORIGIN)) begin
      fr_status_nxt = gsc_pkg::ST_LON_RANGE;
    end else begin
      fr_status_nxt = gsc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_vld_r <= 1'b0;
      sc_vld_r <= 1'b0;
      ix_vld_r <= 1'b0;
    end else begin
      fr_vld_r <= accept;
      sc_vld_r <= c1_lat_valid;
      ix_vld_r <= c2_lat_valid;
    end
  end

  // Front stage: three times the latitude, and the longitude from the 100 degree origin.
  always_ff @(posedge clk) begin
    fr_y_r      <= gsc_pkg::Y_W'({in_data.lat_micro, 1'b0}) + gsc_pkg::Y_W'(in_data.lat_micro);
    fr_d_r      <= in_data.lon_micro - gsc_pkg::LON_W'(gsc_pkg::LON_ORIGIN);
    fr_lvl_r    <= in_data.level;
    fr_status_r <= fr_status_nxt;
  end

  gsc_cdiv #(
    .NUM_W   (gsc_pkg::Y_W),
    .DIVISOR (gsc_pkg::LAT_DIV),
    .QUO_W   (gsc_pkg::LAT1_Q_W),
    .SIDE_W  (gsc_pkg::LVL_W)
  ) u_lat_deg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_vld_r),
    .in_num    (fr_y_r),
    .in_side   (fr_lvl_r),
    .out_valid (c1_lat_valid),
    .out_quo   (c1_lat_quo),
    .out_rem   (c1_lat_rem),
    .out_side  (c1_lvl)
  );

  gsc_cdiv #(
    .NUM_W   (gsc_pkg::D_W),
    .DIVISOR (gsc_pkg::LON_DIV),
    .QUO_W   (gsc_pkg::LON1_Q_W),
    .SIDE_W  (2)
  ) u_lon_deg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_vld_r),
    .in_num    (fr_d_r),
    .in_side   (fr_status_r),
    .out_valid (c1_lon_valid),
    .out_quo   (c1_lon_quo),
    .out_rem   (c1_lon_rem),
    .out_side  (c1_status)
  );

  // The whole degrees scale exactly; only the scaled fraction needs a second divide.
  // The latitude adds one to its scaled fraction before the second divide.
  assign factor = gsc_pkg::level_factor(c1_lvl);

  always_ff @(posedge clk) begin
    sc_t_lat_r <= gsc_pkg::TLAT_W'(factor) * gsc_pkg::TLAT_W'(c1_lat_rem)
                  + gsc_pkg::TLAT_W'(1);
    sc_t_lon_r <= gsc_pkg::TLON_W'(factor) * gsc_pkg::TLON_W'(c1_lon_rem);
    sc_lat_r.lvl    <= c1_lvl;
    sc_lat_r.base   <= gsc_pkg::IDX_W'(factor) * gsc_pkg::IDX_W'(c1_lat_quo);
    sc_lon_r.status <= gsc_pkg::status_t'(c1_status);
    sc_lon_r.base   <= gsc_pkg::IDX_W'(factor) * gsc_pkg::IDX_W'(c1_lon_quo);
  end

  gsc_cdiv #(
    .NUM_W   (gsc_pkg::TLAT_W),
    .DIVISOR (gsc_pkg::LAT_DIV),
    .QUO_W   (gsc_pkg::LAT2_Q_W),
    .SIDE_W  ($bits(lat_side_t))
  ) u_lat_frac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sc_vld_r),
    .in_num    (sc_t_lat_r),
    .in_side   (sc_lat_r),
    .out_valid (c2_lat_valid),
    .out_quo   (c2_lat_quo),
    .out_rem   (),
    .out_side  (c2_lat_side)
  );

  gsc_cdiv #(
    .NUM_W   (gsc_pkg::TLON_W),
    .DIVISOR (gsc_pkg::LON_DIV),
    .QUO_W   (gsc_pkg::LON2_Q_W),
    .SIDE_W  ($bits(lon_side_t))
  ) u_lon_frac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sc_vld_r),
    .in_num    (sc_t_lon_r),
    .in_side   (sc_lon_r),
    .out_valid (c2_lon_valid),
    .out_quo   (c2_lon_quo),
    .out_rem   (),
    .out_side  (c2_lon_side)
  );

  always_ff @(posedge clk) begin
    ix_r.lvl     <= c2_lat_side.lvl;
    ix_r.status  <= c2_lon_side.status;
    ix_r.lat_idx <= c2_lat_side.base + gsc_pkg::IDX_W'(c2_lat_quo);
    ix_r.lon_idx <= c2_lon_side.base + gsc_pkg::IDX_W'(c2_lon_quo);
  end

  gsc_digits u_digits (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ix_vld_r),
    .in_idx    (ix_r),
    .out_valid (out_strobe),
    .out_data  (out_data)
  );

  `GSC_ASSERT_NXT(a_start_enters, clk, rst_n, start, fr_vld_r, "start not taken into the pipeline")
  `GSC_ASSERT_IMP(a_deg_lanes, clk, rst_n, 1'b1, c1_lat_valid == c1_lon_valid, "degree divider lanes out of step")
  `GSC_ASSERT_IMP(a_frac_lanes, clk, rst_n, 1'b1, c2_lat_valid == c2_lon_valid, "fraction divider lanes out of step")
  `GSC_ASSERT_IMP(a_error_clears, clk, rst_n, out_strobe && (out_data.status != gsc_pkg::ST_OK), (out_data.lat_primary == '0) && (out_data.lon_primary == '0) && (out_data.lat_third == '0) && (out_data.half_code == '0) && (out_data.eighth_code == '0), "error result carries digits")
  `GSC_ASSERT_IMP(a_primary_range, clk, rst_n, out_strobe && (out_data.status == gsc_pkg::ST_OK), (out_data.lat_primary < 7'd100) && (out_data.lon_primary < 7'd100), "first-level pair out of range on a good result")

endmodule

@@ rtl/core/gsc_cdiv.sv @@
`include "assert_macros.svh"

// Three-stage divider by a constant: reciprocal multiply, remainder, one correction.
module gsc_cdiv #(
  parameter int NUM_W   = 19,
  parameter int DIVISOR = 10,
  parameter int QUO_W   = 16,
  parameter int SIDE_W  = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [NUM_W-1:0]            in_num,
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        out_valid,
  output logic [QUO_W-1:0]            out_quo,
  output logic [$clog2(DIVISOR)-1:0]  out_rem,
  output logic [SIDE_W-1:0]           out_side
);

  localparam longint RECIP  = (longint'(1) << NUM_W) / DIVISOR;
  localparam int     REM_W  = $clog2(DIVISOR);
  localparam int     PROD_W = NUM_W + QUO_W;

  // Since the numerator stays below 2**NUM_W, the estimate is low by at most one.
  logic [PROD_W-1:0] prod_a;
  logic              vld_a_r;
  logic [NUM_W-1:0]  num_a_r;
  logic [QUO_W-1:0]  quo_a_r;
  logic [SIDE_W-1:0] side_a_r;

  logic [NUM_W-1:0]  diff_b;
  logic              vld_b_r;
  logic [REM_W:0]    rem_b_r;
  logic [QUO_W-1:0]  quo_b_r;
  logic [SIDE_W-1:0] side_b_r;

  logic              ge_c;
  logic [QUO_W-1:0]  quo_c_nxt;
  logic [REM_W-1:0]  rem_c_nxt;
  logic              vld_c_r;
  logic [QUO_W-1:0]  quo_c_r;
  logic [REM_W-1:0]  rem_c_r;
  logic [SIDE_W-1:0] side_c_r;

  assign prod_a = PROD_W'(in_num) * PROD_W'(RECIP);
  assign diff_b = num_a_r - NUM_W'(quo_a_r) * NUM_W'(DIVISOR);
  assign ge_c   = rem_b_r >= (REM_W+1)'(DIVISOR);

  always_comb begin
    if (ge_c) begin
      quo_c_nxt = quo_b_r + QUO_W'(1);
      rem_c_nxt = REM_W'(rem_b_r - (REM_W+1)'(DIVISOR));
    end else begin
      quo_c_nxt = quo_b_r;
      rem_c_nxt = REM_W'(rem_b_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
    end else begin
      vld_a_r <= in_valid;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
    end
  end

  always_ff @(posedge clk) begin
    num_a_r  <= in_num;
    quo_a_r  <= prod_a[NUM_W +: QUO_W];
    side_a_r <= in_side;
    rem_b_r  <= diff_b[REM_W:0];
    quo_b_r  <= quo_a_r;
    side_b_r <= side_a_r;
    quo_c_r  <= quo_c_nxt;
    rem_c_r  <= rem_c_nxt;
    side_c_r <= side_b_r;
  end

  assign out_valid = vld_c_r;
  assign out_quo   = quo_c_r;
  assign out_rem   = rem_c_r;
  assign out_side  = side_c_r;

  `GSC_ASSERT_IMP(a_rem_below_twice, clk, rst_n, vld_b_r, (REM_W+2)'(rem_b_r) < (REM_W+2)'(2 * DIVISOR), "estimated quotient more than one too low")
  `GSC_ASSERT_IMP(a_rem_below_div, clk, rst_n, vld_c_r, (REM_W+1)'(rem_c_r) < (REM_W+1)'(DIVISOR), "corrected remainder not below divisor")
  `GSC_ASSERT_IMP(a_quo_rem_exact, clk, rst_n, vld_c_r, NUM_W'(quo_c_r) * NUM_W'(DIVISOR) + NUM_W'(rem_c_r) == $past(num_a_r, 2), "quotient and remainder do not rebuild numerator")

endmodule

@@ rtl/core/gsc_digits.sv @@
`include "assert_macros.svh"

// Splits the scaled indices into quadrant codes, decimal digit, octal digit
// and the first-level pair, then applies the range checks.
module gsc_digits (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  gsc_pkg::gsc_idx_t in_idx,
  output logic              out_valid,
  output gsc_pkg::gsc_out_t out_data
);

  typedef struct packed {
    logic [gsc_pkg::LVL_W-1:0] lvl;
    logic [gsc_pkg::IDX_W-1:0] v;
    logic [2:0]                half;
    logic [2:0]                quarter;
    logic [2:0]                eighth;
  } lat_side_t;

  typedef struct packed {
    gsc_pkg::status_t          status;
    logic [gsc_pkg::IDX_W-1:0] v;
  } lon_side_t;

  function automatic logic [2:0] quad_code(input logic lat_b, input logic lon_b);
    return {1'b0, lat_b, lon_b} + 3'd1;
  endfunction

  logic [1:0]                  nq;
  lat_side_t                   lat_nxt;
  lon_side_t                   lon_nxt;
  logic                        d1_vld_r;
  lat_side_t                   d1_lat_r;
  lon_side_t                   d1_lon_r;

  logic                        c10_lat_valid;
  logic                        c10_lon_valid;
  logic [gsc_pkg::DEC_Q_W-1:0] c10_lat_quo;
  logic [gsc_pkg::DEC_Q_W-1:0] c10_lon_quo;
  logic [gsc_pkg::DEC_R_W-1:0] c10_lat_rem;
  logic [gsc_pkg::DEC_R_W-1:0] c10_lon_rem;
  lat_side_t                   lat_s;
  lon_side_t                   lon_s;

  logic [gsc_pkg::IDX_W-1:0]   w_lat;
  logic [gsc_pkg::IDX_W-1:0]   w_lon;
  logic [gsc_pkg::IDX_W-1:0]   prim_lat;
  logic [gsc_pkg::IDX_W-1:0]   prim_lon;
  gsc_pkg::status_t            status_fin;
  gsc_pkg::gsc_out_t           out_nxt;
  logic                        out_vld_r;
  gsc_pkg::gsc_out_t           out_r;

  // The finest levels come off the low bits first, one bit pair per level.
  always_comb begin
    lat_nxt        = '0;
    lon_nxt        = '0;
    lat_nxt.lvl    = in_idx.lvl;
    lon_nxt.status = in_idx.status;
    case (in_idx.lvl)
      gsc_pkg::LVL_EIGHTH: begin
        nq              = 2'd3;
        lat_nxt.eighth  = quad_code(in_idx.lat_idx[0], in_idx.lon_idx[0]);
        lat_nxt.quarter = quad_code(in_idx.lat_idx[1], in_idx.lon_idx[1]);
        lat_nxt.half    = quad_code(in_idx.lat_idx[2], in_idx.lon_idx[2]);
      end
      gsc_pkg::LVL_QUARTER: begin
        nq              = 2'd2;
        lat_nxt.quarter = quad_code(in_idx.lat_idx[0], in_idx.lon_idx[0]);
        lat_nxt.half    = quad_code(in_idx.lat_idx[1], in_idx.lon_idx[1]);
      end
      gsc_pkg::LVL_HALF: begin
        nq              = 2'd1;
        lat_nxt.half    = quad_code(in_idx.lat_idx[0], in_idx.lon_idx[0]);
      end
      default: begin
        nq = 2'd0;
      end
    endcase
    lat_nxt.v = in_idx.lat_idx >> nq;
    lon_nxt.v = in_idx.lon_idx >> nq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_vld_r <= 1'b0;
    end else begin
      d1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    d1_lat_r <= lat_nxt;
    d1_lon_r <= lon_nxt;
  end

  gsc_cdiv #(
    .NUM_W   (gsc_pkg::IDX_W),
    .DIVISOR (gsc_pkg::DEC_DIV),
    .QUO_W   (gsc_pkg::DEC_Q_W),
    .SIDE_W  ($bits(lat_side_t))
  ) u_dec_lat (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d1_vld_r),
    .in_num    (d1_lat_r.v),
    .in_side   (d1_lat_r),
    .out_valid (c10_lat_valid),
    .out_quo   (c10_lat_quo),
    .out_rem   (c10_lat_rem),
    .out_side  (lat_s)
  );

  gsc_cdiv #(
    .NUM_W   (gsc_pkg::IDX_W),
    .DIVISOR (gsc_pkg::DEC_DIV),
    .QUO_W   (gsc_pkg::DEC_Q_W),
    .SIDE_W  ($bits(lon_side_t))
  ) u_dec_lon (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d1_vld_r),
    .in_num    (d1_lon_r.v),
    .in_side   (d1_lon_r),
    .out_valid (c10_lon_valid),
    .out_quo   (c10_lon_quo),
    .out_rem   (c10_lon_rem),
    .out_side  (lon_s)
  );

  always_comb begin
    w_lat = (lat_s.lvl >= gsc_pkg::LVL_THIRD) ? gsc_pkg::IDX_W'(c10_lat_quo) : lat_s.v;
    w_lon = (lat_s.lvl >= gsc_pkg::LVL_THIRD) ? gsc_pkg::IDX_W'(c10_lon_quo) : lon_s.v;
    prim_lat = (lat_s.lvl >= gsc_pkg::LVL_SECOND) ? (w_lat >> 3) : w_lat;
    prim_lon = (lat_s.lvl >= gsc_pkg::LVL_SECOND) ? (w_lon >> 3) : w_lon;

    if (lon_s.status != gsc_pkg::ST_OK) begin
      status_fin = lon_s.status;
    end else if (prim_lat >= gsc_pkg::IDX_W'(gsc_pkg::PRIMARY_LIMIT)) begin
      status_fin = gsc_pkg::ST_LAT_RANGE;
    end else if (prim_lon >= gsc_pkg::IDX_W'(gsc_pkg::PRIMARY_LIMIT)) begin
      status_fin = gsc_pkg::ST_LON_RANGE;
    end else begin
      status_fin = gsc_pkg::ST_OK;
    end

    out_nxt        = '0;
    out_nxt.status = status_fin;
    if (status_fin == gsc_pkg::ST_OK) begin
      out_nxt.lat_primary  = prim_lat[6:0];
      out_nxt.lon_primary  = prim_lon[6:0];
      out_nxt.half_code    = lat_s.half;
      out_nxt.quarter_code = lat_s.quarter;
      out_nxt.eighth_code  = lat_s.eighth;
      if (lat_s.lvl >= gsc_pkg::LVL_SECOND) begin
        out_nxt.lat_second = w_lat[2:0];
        out_nxt.lon_second = w_lon[2:0];
      end
      if (lat_s.lvl >= gsc_pkg::LVL_THIRD) begin
        out_nxt.lat_third = c10_lat_rem;
        out_nxt.lon_third = c10_lon_rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= c10_lat_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  `GSC_ASSERT_IMP(a_dec_lanes, clk, rst_n, 1'b1, c10_lat_valid == c10_lon_valid, "decimal divider lanes out of step")
  `GSC_ASSERT_IMP(a_eighth_only_top, clk, rst_n, d1_vld_r && (d1_lat_r.lvl != gsc_pkg::LVL_EIGHTH), d1_lat_r.eighth == 3'd0, "eighth code set below the finest level")
  `GSC_ASSERT_NXT(a_third_digit, clk, rst_n, c10_lat_valid, out_valid && (out_data.lat_third <= 4'd9) && (out_data.lon_third <= 4'd9), "third-level digit not decimal")

endmodule
